// File: src/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants for the doctype token scanner
// Phase encoding, span kinds, character codes and keyword tables.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int OFFSET_WIDTH_DEF = 16;
  localparam int FIELD_WIDTH      = 16;
  localparam int KW_LEN           = 6;

  typedef enum logic [3:0] {
    PH_DONE         = 4'd0,
    PH_BEFORE_NAME  = 4'd1,
    PH_NAME         = 4'd2,
    PH_AFTER_NAME   = 4'd3,
    PH_KEYWORD      = 4'd4,
    PH_BEFORE_ID    = 4'd5,
    PH_PUB_ID       = 4'd6,
    PH_AFTER_PUB_ID = 4'd7,
    PH_SYS_ID       = 4'd8,
    PH_AFTER_SYS_ID = 4'd9,
    PH_BOGUS        = 4'd10
  } phase_t;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_KEYWORD = 2'd1;
  localparam logic [1:0] KIND_PUBLIC  = 2'd2;
  localparam logic [1:0] KIND_SYSTEM  = 2'd3;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // one result word
  typedef struct packed {
    logic                   attr_valid;
    logic [1:0]             attr_kind;
    logic [FIELD_WIDTH-1:0] attr_start;
    logic [FIELD_WIDTH-1:0] attr_length;
    logic                   token_end;
    logic                   quirks;
    logic                   in_doctype;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) ||
           (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ? (c - CASE_GAP) : c;
  endfunction

  function automatic logic [7:0] kw_public(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = "P";
      3'd1:    ch = "U";
      3'd2:    ch = "B";
      3'd3:    ch = "L";
      3'd4:    ch = "I";
      default: ch = "C";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_system(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = "S";
      3'd1:    ch = "Y";
      3'd2:    ch = "S";
      3'd3:    ch = "T";
      3'd4:    ch = "E";
      default: ch = "M";
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: src/dts_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_scan: doctype phase machine
// Holds the scan state and steps it by one word when step_en is high.
// ----------------------------------------------------------------------------
module dts_scan #(
  parameter int OFFSET_WIDTH = dts_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire logic            op,
  input  wire logic [7:0]      byte_in,
  output dts_pkg::result_t     result
);
  import dts_pkg::*;

  localparam logic [2:0] KW_LAST = 3'(KW_LEN - 1);
  localparam logic [2:0] KW_FULL = 3'(KW_LEN);

  phase_t                  phase_r, phase_nxt, phase_step;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic [OFFSET_WIDTH-1:0] span_r, span_nxt;
  logic                    quote_r, quote_nxt;
  logic [2:0]              kwcnt_r, kwcnt_nxt;
  logic [1:0]              kwcand_r, kwcand_nxt;
  logic                    quirks_r, quirks_nxt;

  logic                    sp, gt;
  logic [7:0]              up, quote_ch;
  logic [2:0]              kc, k;
  logic [1:0]              kd, cand_new;
  logic [OFFSET_WIDTH-1:0] kspan;
  logic                    valid, tend;
  logic [1:0]              kind;
  logic [OFFSET_WIDTH-1:0] start, len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      span_r   <= '0;
      quote_r  <= 1'b0;
      kwcnt_r  <= 3'd0;
      kwcand_r <= 2'b11;
      quirks_r <= 1'b0;
    end else if (step_en) begin
      pos_r    <= pos_nxt;
      span_r   <= span_nxt;
      quote_r  <= quote_nxt;
      kwcnt_r  <= kwcnt_nxt;
      kwcand_r <= kwcand_nxt;
      quirks_r <= quirks_nxt;
    end
  end

  always_comb begin
    sp       = is_space(byte_in);
    gt       = (byte_in == CH_GT);
    up       = to_upper(byte_in);
    quote_ch = quote_r ? CH_SQUOTE : CH_DQUOTE;

    // keyword state as seen by this byte (fresh when entering from after-name)
    kc    = (phase_r == PH_KEYWORD) ? kwcnt_r : 3'd0;
    kd    = (phase_r == PH_KEYWORD) ? kwcand_r : 2'b11;
    kspan = (phase_r == PH_KEYWORD) ? span_r : pos_r;
    k     = (kc < KW_FULL) ? kc : KW_LAST;
    cand_new = kd & {(up == kw_system(k)), (up == kw_public(k))};

    phase_step = phase_r;
    span_nxt   = span_r;
    quote_nxt  = quote_r;
    kwcnt_nxt  = kwcnt_r;
    kwcand_nxt = kwcand_r;
    quirks_nxt = quirks_r;
    valid      = 1'b0;
    kind       = KIND_NAME;
    tend       = 1'b0;
    start      = '0;
    len        = '0;

    case (phase_r)
      PH_BEFORE_NAME: begin
        if (!sp) begin
          if (gt) begin
            quirks_nxt = 1'b1;
            tend       = 1'b1;
          end else begin
            span_nxt   = pos_r;
            phase_step = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (gt || sp) begin
          valid = 1'b1;
          kind  = KIND_NAME;
          start = span_r;
          len   = pos_r - span_r;
          if (gt) tend = 1'b1;
          else    phase_step = PH_AFTER_NAME;
        end
      end
      PH_AFTER_NAME, PH_KEYWORD: begin
        if ((phase_r == PH_AFTER_NAME) && sp) begin
          phase_step = phase_r;
        end else if ((phase_r == PH_AFTER_NAME) && gt) begin
          tend = 1'b1;
        end else begin
          span_nxt   = kspan;
          kwcnt_nxt  = kc;
          kwcand_nxt = cand_new;
          phase_step = PH_KEYWORD;
          if (cand_new == 2'b00) begin
            quirks_nxt = 1'b1;
            if (gt) tend = 1'b1;
            else    phase_step = PH_BOGUS;
          end else begin
            kwcnt_nxt = k + 3'd1;
            if ((k + 3'd1) == KW_FULL) begin
              valid      = 1'b1;
              kind       = KIND_KEYWORD;
              start      = kspan;
              len        = OFFSET_WIDTH'(KW_LEN);
              phase_step = cand_new[0] ? PH_BEFORE_ID : PH_AFTER_PUB_ID;
            end
          end
        end
      end
      PH_BEFORE_ID, PH_AFTER_PUB_ID: begin
        if (!sp) begin
          if ((byte_in == CH_DQUOTE) || (byte_in == CH_SQUOTE)) begin
            quote_nxt  = (byte_in == CH_SQUOTE);
            span_nxt   = pos_r + 1'b1;
            phase_step = (phase_r == PH_BEFORE_ID) ? PH_PUB_ID : PH_SYS_ID;
          end else if (gt) begin
            if (phase_r == PH_BEFORE_ID) quirks_nxt = 1'b1;
            tend = 1'b1;
          end else begin
            quirks_nxt = 1'b1;
            phase_step = PH_BOGUS;
          end
        end
      end
      PH_PUB_ID, PH_SYS_ID: begin
        if ((byte_in == quote_ch) || gt) begin
          valid = 1'b1;
          kind  = (phase_r == PH_PUB_ID) ? KIND_PUBLIC : KIND_SYSTEM;
          start = span_r;
          len   = pos_r - span_r;
          if (gt) begin
            quirks_nxt = 1'b1;
            tend       = 1'b1;
          end else begin
            phase_step = (phase_r == PH_PUB_ID) ? PH_AFTER_PUB_ID : PH_AFTER_SYS_ID;
          end
        end
      end
      PH_AFTER_SYS_ID: begin
        if (!sp) begin
          if (gt) tend = 1'b1;
          else    phase_step = PH_BOGUS;
        end
      end
      PH_BOGUS: begin
        if (gt) tend = 1'b1;
      end
      default: begin
        phase_step = PH_DONE;
      end
    endcase

    phase_nxt = tend ? PH_DONE : phase_step;
    pos_nxt   = (phase_nxt != PH_DONE) ? (pos_r + 1'b1) : pos_r;

    result.attr_valid  = valid;
    result.attr_kind   = kind;
    result.attr_start  = FIELD_WIDTH'(start);
    result.attr_length = FIELD_WIDTH'(len);
    result.token_end   = tend;
    result.quirks      = quirks_nxt;
    result.in_doctype  = (phase_nxt != PH_DONE);

    if (op == OP_START) begin
      phase_nxt  = PH_BEFORE_NAME;
      pos_nxt    = '0;
      span_nxt   = '0;
      quote_nxt  = 1'b0;
      kwcnt_nxt  = 3'd0;
      kwcand_nxt = 2'b11;
      quirks_nxt = 1'b0;
      result     = '0;
      result.in_doctype = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: src/doctype_token_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// doctype_token_scanner_core: DOCTYPE body scanner
// Steps the doctype phases one byte per word and reports closed spans.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_op, in_byte_in
//  out     | out | out_valid / out_ready | out_attr_*, out_token_end,
//          |     |                       | out_quirks, out_in_doctype
//
//  One word per cycle sustained while out_ready stays high. A word passes
//  the input register and then the result register, and out_valid rises
//  when it is written into the result register; the phase update is
//  combinational logic between the two registers.
//  When out_ready is low the result holds, one more word waits in the
//  input register, then in_ready drops.
//  Reset is synchronous active low and returns the scanner to idle.
// ----------------------------------------------------------------------------
module doctype_token_scanner_core #(
  parameter int OFFSET_WIDTH = dts_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_attr_valid,
  output logic [1:0]       out_attr_kind,
  output logic [15:0]      out_attr_start,
  output logic [15:0]      out_attr_length,
  output logic             out_token_end,
  output logic             out_quirks,
  output logic             out_in_doctype
);
  import dts_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic       in_op_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r, out_vld_nxt;
  result_t    res_r;
  result_t    step_res;
  logic       fire, in_acc;

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    in_vld_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : in_vld_r);
    out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r   <= in_op;
      in_byte_r <= in_byte_in;
    end
    if (fire) begin
      res_r <= step_res;
    end
  end

  dts_scan #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .op      (in_op_r),
    .byte_in (in_byte_r),
    .result  (step_res)
  );

  assign out_valid       = out_vld_r;
  assign out_attr_valid  = res_r.attr_valid;
  assign out_attr_kind   = res_r.attr_kind;
  assign out_attr_start  = res_r.attr_start;
  assign out_attr_length = res_r.attr_length;
  assign out_token_end   = res_r.token_end;
  assign out_quirks      = res_r.quirks;
  assign out_in_doctype  = res_r.in_doctype;

endmodule
`default_nettype wire

// File: src/dts_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_chk: port-level checks for the doctype token scanner
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module dts_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_attr_valid,
  input wire logic [1:0]  out_attr_kind,
  input wire logic [15:0] out_attr_start,
  input wire logic [15:0] out_attr_length,
  input wire logic        out_token_end,
  input wire logic        out_quirks,
  input wire logic        out_in_doctype
);
  import dts_pkg::*;

  // no result shows up in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_attr_valid) &&
      $stable(out_attr_start) && $stable(out_attr_length) &&
      $stable(out_attr_kind) && $stable(out_token_end) &&
      $stable(out_quirks) && $stable(out_in_doctype))
    else $error("stalled result changed");

  // closing '>' leaves the doctype
  a_end_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_end |-> !out_in_doctype)
    else $error("token_end while still in doctype");

  // span fields are zero unless a span closed
  a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_attr_valid |->
      out_attr_kind == KIND_NAME && out_attr_start == '0 && out_attr_length == '0)
    else $error("span fields set without a closed span");

  // a keyword span is always six bytes long
  a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_attr_valid && out_attr_kind == KIND_KEYWORD |->
      out_attr_length == 16'(KW_LEN))
    else $error("keyword span with wrong length");

endmodule

bind doctype_token_scanner_core dts_chk u_dts_chk (.*);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: doctype token scanner testbench
// Streams doctype bodies into the scanner, predicts each result word from a
// behavioral copy of the phase machine, and checks every returned word in
// order. Covers directed phase paths, random well-formed and broken doctypes
// with random idling on both channels, and an idle-free stream at the end.
// ----------------------------------------------------------------------------
module tb;
  import dts_pkg::*;

  localparam int OW = OFFSET_WIDTH_DEF;
  localparam logic [47:0] PUB_TXT = "PUBLIC";
  localparam logic [47:0] SYS_TXT = "SYSTEM";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_ready;
  logic        out_attr_valid;
  logic [1:0]  out_attr_kind;
  logic [15:0] out_attr_start;
  logic [15:0] out_attr_length;
  logic        out_token_end;
  logic        out_quirks;
  logic        out_in_doctype;

  // scanner shadow state
  phase_t        ph;
  logic [OW-1:0] pos;
  logic [OW-1:0] span_beg;
  logic          q_single;
  logic [2:0]    kw_cnt;
  logic [1:0]    kw_cand;
  logic          quirk_st;

  result_t     scan_results_due[$];
  result_t     head;
  int unsigned err_cnt    = 0;
  int unsigned live_words = 0;
  logic        src_idle   = 1'b0;
  logic        sink_idle  = 1'b0;

  doctype_token_scanner_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_attr_valid (out_attr_valid),
    .out_attr_kind  (out_attr_kind),
    .out_attr_start (out_attr_start),
    .out_attr_length(out_attr_length),
    .out_token_end  (out_token_end),
    .out_quirks     (out_quirks),
    .out_in_doctype (out_in_doctype)
  );

  always #4 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] keyword_char(input logic pub, input logic [2:0] k);
    return pub ? PUB_TXT[8*(5-k) +: 8] : SYS_TXT[8*(5-k) +: 8];
  endfunction

  function automatic void clear_scanner();
    ph       = PH_DONE;
    pos      = '0;
    span_beg = '0;
    q_single = 1'b0;
    kw_cnt   = 3'd0;
    kw_cand  = 2'b11;
    quirk_st = 1'b0;
  endfunction

  // advances the shadow scanner by one word and returns the expected result
  function automatic result_t advance_scanner(input logic op, input logic [7:0] c);
    result_t    r;
    logic       tend;
    logic [2:0] k;
    logic [7:0] u;
    logic [7:0] qch;
    r    = '0;
    tend = 1'b0;
    if (op == OP_START) begin
      clear_scanner();
      ph = PH_BEFORE_NAME;
      r.in_doctype = 1'b1;
      return r;
    end
    qch = q_single ? CH_SQUOTE : CH_DQUOTE;
    case (ph)
      PH_BEFORE_NAME: begin
        if (!is_blank(c)) begin
          if (c == CH_GT) begin
            quirk_st = 1'b1;
            tend = 1'b1;
          end else begin
            span_beg = pos;
            ph = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (c == CH_GT || is_blank(c)) begin
          r.attr_valid  = 1'b1;
          r.attr_kind   = KIND_NAME;
          r.attr_start  = span_beg;
          r.attr_length = pos - span_beg;
          if (c == CH_GT) tend = 1'b1;
          else ph = PH_AFTER_NAME;
        end
      end
      PH_AFTER_NAME, PH_KEYWORD: begin
        if (ph == PH_AFTER_NAME && !is_blank(c)) begin
          if (c == CH_GT) begin
            tend = 1'b1;
          end else begin
            span_beg = pos;
            kw_cnt   = 3'd0;
            kw_cand  = 2'b11;
            ph       = PH_KEYWORD;
          end
        end
        if (ph == PH_KEYWORD) begin
          k = (kw_cnt < 3'd6) ? kw_cnt : 3'd5;
          u = fold_case(c);
          if (u != keyword_char(1'b1, k)) kw_cand[0] = 1'b0;
          if (u != keyword_char(1'b0, k)) kw_cand[1] = 1'b0;
          if (kw_cand == 2'b00) begin
            quirk_st = 1'b1;
            if (c == CH_GT) tend = 1'b1;
            else ph = PH_BOGUS;
          end else begin
            kw_cnt = k + 3'd1;
            if (kw_cnt == 3'd6) begin
              r.attr_valid  = 1'b1;
              r.attr_kind   = KIND_KEYWORD;
              r.attr_start  = span_beg;
              r.attr_length = 16'd6;
              ph = kw_cand[0] ? PH_BEFORE_ID : PH_AFTER_PUB_ID;
            end
          end
        end
      end
      PH_BEFORE_ID, PH_AFTER_PUB_ID: begin
        if (!is_blank(c)) begin
          if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            q_single = (c == CH_SQUOTE);
            span_beg = pos + 1'b1;
            ph = (ph == PH_BEFORE_ID) ? PH_PUB_ID : PH_SYS_ID;
          end else if (c == CH_GT) begin
            if (ph == PH_BEFORE_ID) quirk_st = 1'b1;
            tend = 1'b1;
          end else begin
            quirk_st = 1'b1;
            ph = PH_BOGUS;
          end
        end
      end
      PH_PUB_ID, PH_SYS_ID: begin
        if (c == qch || c == CH_GT) begin
          r.attr_valid  = 1'b1;
          r.attr_kind   = (ph == PH_PUB_ID) ? KIND_PUBLIC : KIND_SYSTEM;
          r.attr_start  = span_beg;
          r.attr_length = pos - span_beg;
          if (c == CH_GT) begin
            quirk_st = 1'b1;
            tend = 1'b1;
          end else begin
            ph = (ph == PH_PUB_ID) ? PH_AFTER_PUB_ID : PH_AFTER_SYS_ID;
          end
        end
      end
      PH_AFTER_SYS_ID: begin
        if (!is_blank(c)) begin
          if (c == CH_GT) tend = 1'b1;
          else ph = PH_BOGUS;
        end
      end
      PH_BOGUS: begin
        if (c == CH_GT) tend = 1'b1;
      end
      default: ph = PH_DONE;
    endcase
    if (tend) ph = PH_DONE;
    if (ph != PH_DONE) pos = pos + 1'b1;
    r.token_end  = tend;
    r.quirks     = quirk_st;
    r.in_doctype = (ph != PH_DONE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, 32'd0);
      end else begin
        head = scan_results_due.pop_front();
        if (out_attr_valid !== head.attr_valid)
          report_mismatch("attr_valid", 32'(out_attr_valid), 32'(head.attr_valid));
        if (out_attr_kind !== head.attr_kind)
          report_mismatch("attr_kind", 32'(out_attr_kind), 32'(head.attr_kind));
        if (out_attr_start !== head.attr_start)
          report_mismatch("attr_start", 32'(out_attr_start), 32'(head.attr_start));
        if (out_attr_length !== head.attr_length)
          report_mismatch("attr_length", 32'(out_attr_length), 32'(head.attr_length));
        if (out_token_end !== head.token_end)
          report_mismatch("token_end", 32'(out_token_end), 32'(head.token_end));
        if (out_quirks !== head.quirks)
          report_mismatch("quirks", 32'(out_quirks), 32'(head.quirks));
        if (out_in_doctype !== head.in_doctype)
          report_mismatch("in_doctype", 32'(out_in_doctype), 32'(head.in_doctype));
      end
    end
  end

  // result-side backpressure
  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (sink_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    live_words++;
    scan_results_due.push_back(advance_scanner(op, b));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (is_blank(c) || c == CH_GT) ? 8'h6E : c;
  endfunction

  function automatic logic [7:0] id_byte(input logic [7:0] q);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == q || c == CH_GT) ? 8'h69 : c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_FF;
      3:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic send_blanks(input int unsigned n);
    repeat (n) send_word(OP_BYTE, blank_byte());
  endtask

  task automatic send_keyword(input logic pub, input int unsigned n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = keyword_char(pub, 3'(i));
      if ($urandom_range(0, 1)) c = c | 8'h20;
      send_word(OP_BYTE, c);
    end
  endtask

  task automatic send_quoted();
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    send_word(OP_BYTE, q);
    repeat ($urandom_range(0, 6)) send_word(OP_BYTE, id_byte(q));
    send_word(OP_BYTE, ($urandom_range(0, 14) == 0) ? CH_GT : q);
  endtask

  task automatic random_noise();
    repeat ($urandom_range(5, 20))
      send_word($urandom_range(0, 9) == 0 ? OP_START : OP_BYTE,
                8'($urandom_range(0, 255)));
  endtask

  task automatic random_doctype();
    int unsigned pick;
    logic        pub;
    send_word(OP_START, 8'($urandom_range(0, 255)));
    send_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 19) == 0) send_word(OP_BYTE, CH_GT);
    if (ph == PH_DONE) return;
    repeat (($urandom_range(0, 29) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4))
      send_word(OP_BYTE, name_byte());
    if ($urandom_range(0, 9) == 0) send_word(OP_BYTE, CH_GT);
    else send_blanks($urandom_range(1, 2));
    if (ph == PH_DONE) return;
    pick = $urandom_range(0, 11);
    pub  = (pick < 7);
    if (pick == 0) begin
      send_word(OP_BYTE, CH_GT);
      return;
    end
    if (pick == 1) begin
      send_keyword(1'($urandom_range(0, 1)), $urandom_range(0, 5));
      send_word(OP_BYTE, $urandom_range(0, 3) == 0 ? CH_GT : 8'($urandom_range(0, 255)));
    end else begin
      send_keyword(pub, 6);
      if ($urandom_range(0, 9) == 0) send_word(OP_BYTE, name_byte());
      send_blanks($urandom_range(0, 2));
      if (pub && $urandom_range(0, 9) == 0) send_word(OP_BYTE, CH_GT);
      if (ph == PH_DONE) return;
      if (ph == PH_BEFORE_ID || ph == PH_AFTER_PUB_ID) send_quoted();
      if (ph == PH_DONE) return;
      send_blanks($urandom_range(0, 2));
      if (ph == PH_AFTER_PUB_ID && $urandom_range(0, 2) != 0) send_quoted();
      if (ph == PH_DONE) return;
      send_blanks($urandom_range(0, 2));
    end
    pick = $urandom_range(0, 9);
    if (pick >= 7 && pick <= 8)
      repeat ($urandom_range(1, 3)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
    if (pick != 9 && ph != PH_DONE) send_word(OP_BYTE, CH_GT);
  endtask

  task automatic test_idle_bytes();
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
  endtask

  task automatic test_system_path();
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, CH_TAB);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, CH_LF);
    send_text("sYsTeM'");
    send_word(OP_BYTE, 8'hFF);
    send_text("'");
    send_word(OP_BYTE, CH_CR);
    send_text("x>");
  endtask

  task automatic test_public_path();
    send_word(OP_START, 8'hFF);
    send_text("a");
    send_word(OP_BYTE, CH_FF);
    send_text("PUBLIC\"\"\">");
  endtask

  task automatic test_keyword_mismatch();
    send_word(OP_START, 8'h00);
    send_text("a P>");
    send_word(OP_START, 8'h00);
    send_text(">");
  endtask

  task automatic test_random_doctypes();
    int unsigned base;
    int unsigned n;
    base = live_words;
    n    = 0;
    while (live_words - base < 1600) begin
      if (n % 40 == 0) begin
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 7) == 0) random_noise();
      else random_doctype();
      n++;
    end
  endtask

  // back-to-back words with both sides always ready
  task automatic test_steady_stream();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (8) random_doctype();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_BYTE;
    in_byte_in = 8'h00;
    clear_scanner();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_system_path();
    test_public_path();
    test_keyword_mismatch();
    drain();
    test_random_doctypes();
    drain();
    test_steady_stream();
    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
